// ===== rtl/core/power_mode_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// power mode controller assertion macros
// shared property forms for the checks in the rtl
// ----------------------------------------------------------------------------
`ifndef POWER_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define POWER_MODE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pmc assertion failed");

// next-cycle implication, disabled during reset
`define PMC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pmc assertion failed");

`endif

// ===== rtl/core/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg
// types and codes of the power mode controller
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int CFG_WIDTH = 16;
	localparam int CFG_IDX_WIDTH = 3;

	typedef enum logic [1:0] {
		PM_ACTIVE  = 2'd0,
		PM_STANDBY = 2'd1,
		PM_SLEEP   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_MOTION = 2'd1,
		KIND_BUTTON = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_SLEEP_TIMEOUT   = 3'd0,
		REG_SAMPLE_INTERVAL = 3'd1,
		REG_HB_INTERVAL     = 3'd2,
		REG_DEBOUNCE        = 3'd3,
		REG_BLINK_PERIOD    = 3'd4,
		REG_PULSE_PERIOD    = 3'd5
	} reg_idx_t;

	localparam logic [CFG_WIDTH-1:0] RST_SLEEP_TIMEOUT   = 16'd30000;
	localparam logic [CFG_WIDTH-1:0] RST_SAMPLE_INTERVAL = 16'd5000;
	localparam logic [CFG_WIDTH-1:0] RST_HB_INTERVAL     = 16'd2000;
	localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE        = 16'd10;
	localparam logic [CFG_WIDTH-1:0] RST_BLINK_PERIOD    = 16'd800;
	localparam logic [CFG_WIDTH-1:0] RST_PULSE_PERIOD    = 16'd2000;

endpackage

// ===== rtl/core/power_mode_controller_unit.sv =====
// the result beat is registered and valid in the cycle after its input beat is accepted
// throughput: one beat per cycle; the result register is refilled in the
// same cycle it is taken, so input ready only drops while a result stalls
// reset: asynchronous active low; mode active, led off, counters cleared,
// button, blink and pulse timers saturated, registers at their defaults
// ----------------------------------------------------------------------------
// power_mode_controller_unit
// three-mode power controller driven by tick, motion and button events
// ----------------------------------------------------------------------------
`include "power_mode_controller_unit_assert.svh"

module power_mode_controller_unit #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pmc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [pmc_pkg::CFG_WIDTH-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic                                button_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          mode,
	output logic                                led_on,
	output logic                                sample_request,
	output logic                                heartbeat_pulse,
	output logic                                sleep_pulse,
	output logic                                entered_sleep,
	output logic                                woke,
	output logic                                button_accepted,
	output logic [31:0]                         sleep_entries
);
	import pmc_pkg::*;

	localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	typedef logic [TIMER_WIDTH-1:0] tmr_t;

	function automatic tmr_t sat_inc(input tmr_t v);
		return (v == TMAX) ? TMAX : v + 1'b1;
	endfunction

	function automatic logic reached(input tmr_t e, input logic [CFG_WIDTH-1:0] r);
		return CW'(e) >= CW'(r);
	endfunction

	// configuration
	logic [CFG_WIDTH-1:0] sleep_to_q, sample_iv_q, hb_iv_q, debounce_q, blink_q, pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_to_q  <= RST_SLEEP_TIMEOUT;
			sample_iv_q <= RST_SAMPLE_INTERVAL;
			hb_iv_q     <= RST_HB_INTERVAL;
			debounce_q  <= RST_DEBOUNCE;
			blink_q     <= RST_BLINK_PERIOD;
			pulse_q     <= RST_PULSE_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLEEP_TIMEOUT:   sleep_to_q  <= cfg_wdata;
				REG_SAMPLE_INTERVAL: sample_iv_q <= cfg_wdata;
				REG_HB_INTERVAL:     hb_iv_q     <= cfg_wdata;
				REG_DEBOUNCE:        debounce_q  <= cfg_wdata;
				REG_BLINK_PERIOD:    blink_q     <= cfg_wdata;
				REG_PULSE_PERIOD:    pulse_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// state; mode, led and sleep count double as result fields
	mode_t       mode_q, mode_n;
	logic        led_q, led_n;
	logic [31:0] sleep_cnt_q, sleep_cnt_n;
	tmr_t        motion_q, sample_q, hb_q, button_q, blink_el_q, pulse_el_q;
	tmr_t        motion_n, sample_n, hb_n, button_n, blink_el_n, pulse_el_n;
	logic        f_sample, f_hb, f_pulse, f_enter, f_woke, f_btn;

	logic out_valid_q;
	logic f_sample_q, f_hb_q, f_pulse_q, f_enter_q, f_woke_q, f_btn_q;
	logic in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		mode_n      = mode_q;
		led_n       = led_q;
		sleep_cnt_n = sleep_cnt_q;
		motion_n    = motion_q;
		sample_n    = sample_q;
		hb_n        = hb_q;
		button_n    = button_q;
		blink_el_n  = blink_el_q;
		pulse_el_n  = pulse_el_q;
		f_sample    = 1'b0;
		f_hb        = 1'b0;
		f_pulse     = 1'b0;
		f_enter     = 1'b0;
		f_woke      = 1'b0;
		f_btn       = 1'b0;
		case (kind)
			KIND_TICK: begin
				motion_n   = sat_inc(motion_q);
				sample_n   = sat_inc(sample_q);
				hb_n       = sat_inc(hb_q);
				button_n   = sat_inc(button_q);
				blink_el_n = sat_inc(blink_el_q);
				pulse_el_n = sat_inc(pulse_el_q);
				if (mode_q == PM_ACTIVE && reached(motion_n, sleep_to_q)) begin
					mode_n      = PM_SLEEP;
					sleep_cnt_n = sleep_cnt_q + 32'd1;
					led_n       = 1'b0;
					f_enter     = 1'b1;
				end
				// checks follow the mode after a possible sleep entry
				case (mode_n)
					PM_ACTIVE: begin
						if (reached(sample_n, sample_iv_q)) begin
							sample_n = '0;
							f_sample = 1'b1;
						end
						if (reached(hb_n, hb_iv_q)) begin
							hb_n = '0;
							f_hb = 1'b1;
						end
					end
					PM_STANDBY: begin
						if (reached(blink_el_n, blink_q)) begin
							blink_el_n = '0;
							led_n      = !led_n;
						end
					end
					PM_SLEEP: begin
						if (reached(pulse_el_n, pulse_q)) begin
							pulse_el_n = '0;
							f_pulse    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			KIND_MOTION: begin
				if (mode_q == PM_SLEEP) begin
					mode_n = PM_ACTIVE;
					f_woke = 1'b1;
				end
				motion_n = '0;
			end
			KIND_BUTTON: begin
				if (reached(button_q, debounce_q)) begin
					button_n = '0;
					f_btn    = 1'b1;
					if (!button_level) begin
						led_n  = !led_q;
						mode_n = PM_STANDBY;
					end else begin
						mode_n = PM_ACTIVE;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= PM_ACTIVE;
			led_q       <= 1'b0;
			sleep_cnt_q <= '0;
			motion_q    <= '0;
			sample_q    <= '0;
			hb_q        <= '0;
			button_q    <= TMAX;
			blink_el_q  <= TMAX;
			pulse_el_q  <= TMAX;
		end else if (in_fire) begin
			mode_q      <= mode_n;
			led_q       <= led_n;
			sleep_cnt_q <= sleep_cnt_n;
			motion_q    <= motion_n;
			sample_q    <= sample_n;
			hb_q        <= hb_n;
			button_q    <= button_n;
			blink_el_q  <= blink_el_n;
			pulse_el_q  <= pulse_el_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result flags, loaded only with a new beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			f_sample_q <= f_sample;
			f_hb_q     <= f_hb;
			f_pulse_q  <= f_pulse;
			f_enter_q  <= f_enter;
			f_woke_q   <= f_woke;
			f_btn_q    <= f_btn;
		end
	end

	assign out_valid       = out_valid_q;
	assign mode            = mode_q;
	assign led_on          = led_q;
	assign sample_request  = f_sample_q;
	assign heartbeat_pulse = f_hb_q;
	assign sleep_pulse     = f_pulse_q;
	assign entered_sleep   = f_enter_q;
	assign woke            = f_woke_q;
	assign button_accepted = f_btn_q;
	assign sleep_entries   = sleep_cnt_q;

	`PMC_ASSERT_IMP(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready)
	`PMC_ASSERT_IMP(a_enter_means_sleep_dark, out_valid_q && f_enter_q,
		mode_q == PM_SLEEP && !led_q && !f_sample_q && !f_hb_q)
	`PMC_ASSERT_IMP(a_woke_means_active, out_valid_q && f_woke_q, mode_q == PM_ACTIVE)
	`PMC_ASSERT_NXT(a_enter_counts, in_fire && f_enter,
		sleep_cnt_q == $past(sleep_cnt_q) + 32'd1)
	`PMC_ASSERT_NXT(a_count_holds, in_fire && !f_enter, $stable(sleep_cnt_q))

endmodule
